// File: sv/priority_ready_queue_scheduler_assert.svh
// Assertion macros used by the scheduler core.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define PRQ_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prq: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prq: next-cycle check failed");

`endif

// File: sv/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

   // Table sizes
   localparam int THREADS = 8;
   localparam int LEVELS  = 16;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int THREAD_W = 3;
   localparam int PRI_W    = 4;
   localparam int STATUS_W = 2;

   // Index widths into the tables
   localparam int TIDX_W = $clog2(THREADS);
   localparam int LIDX_W = $clog2(LEVELS);

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_REMOVE   = 2'd1,
      KIND_SETPRI   = 2'd2,
      KIND_SCHEDULE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [THREAD_W-1:0] chosen_thread;
      logic [PRI_W-1:0]    old_priority;
   } result_type;

endpackage

`default_nettype wire

// File: sv/prq_level_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module prq_level_pick
   import prq_pkg::*;
(
   input  wire logic [LEVELS-1:0] nonempty,
   output logic                   any,
   output logic [LIDX_W-1:0]      level
);

   // Find the lowest-numbered non-empty level; level 0 is most urgent
   always_comb begin
      level = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            level = LIDX_W'(i);
         end
      end
   end

   assign any = |nonempty;

endmodule

`default_nettype wire

// File: sv/prq_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "priority_ready_queue_scheduler_assert.svh"

module prq_core
   import prq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire kind_type            kind,
   input  wire logic [THREAD_W-1:0] thread,
   input  wire logic [PRI_W-1:0]    new_priority,
   output result_type               result
);

   // Link tables: no reset, only entries that were written are ever read
   logic [TIDX_W-1:0] head_ff [LEVELS];
   logic [TIDX_W-1:0] tail_ff [LEVELS];
   logic [TIDX_W-1:0] link_ff [THREADS];

   // Control state
   logic [LEVELS-1:0]  nonempty_ff, nonempty_in;
   logic [THREADS-1:0] ready_ff, ready_in;
   logic [PRI_W-1:0]   pri_ff [THREADS];
   logic [PRI_W-1:0]   pri_in [THREADS];

   logic              t_ok;
   logic [TIDX_W-1:0] tid;
   logic [PRI_W-1:0]  pri_rd;
   logic [LIDX_W-1:0] lvl;
   logic              win_any;
   logic [LIDX_W-1:0] win_lvl;
   logic [LIDX_W-1:0] head_addr;
   logic [TIDX_W-1:0] head_rd;
   logic [TIDX_W-1:0] tail_rd;
   logic [TIDX_W-1:0] link_rd;
   logic [PRI_W-1:0]  sat_pri;

   logic              head_we, tail_we, link_we;
   logic [TIDX_W-1:0] head_wd, link_wa;

   // Decode the thread and look up its level
   assign tid    = thread[TIDX_W-1:0];
   assign t_ok   = (32'(thread) < THREADS);
   assign pri_rd = pri_ff[tid];
   assign lvl    = (32'(pri_rd) < LEVELS) ? LIDX_W'(pri_rd) : LIDX_W'(LEVELS - 1);

   // Clamp a requested priority to the last level
   assign sat_pri = (32'(new_priority) > LEVELS - 1) ? PRI_W'(LEVELS - 1) : new_priority;

   prq_level_pick u_pick (
      .nonempty (nonempty_ff),
      .any      (win_any),
      .level    (win_lvl)
   );

   // One read port on the head table, shared by schedule and the queue ops
   assign head_addr = (kind == KIND_SCHEDULE) ? win_lvl : lvl;
   assign head_rd   = head_ff[head_addr];
   assign tail_rd   = tail_ff[lvl];
   assign link_rd   = link_ff[tid];

   // Work out the result and the state update for the item in the input register
   always_comb begin
      result      = '{status: ST_NOCHANGE, chosen_thread: '0, old_priority: '0};
      nonempty_in = nonempty_ff;
      ready_in    = ready_ff;
      pri_in      = pri_ff;
      head_we     = 1'b0;
      tail_we     = 1'b0;
      link_we     = 1'b0;
      head_wd     = tid;
      link_wa     = tail_rd;

      if (kind == KIND_SCHEDULE) begin
         if (win_any) begin
            result.status        = ST_DONE;
            result.chosen_thread = THREAD_W'(head_rd);
         end else begin
            result.status = ST_EMPTY;
         end
      end else if (t_ok) begin
         unique case (kind)
            KIND_ENQUEUE: begin
               if (!ready_ff[tid]) begin
                  // Append at the tail, or start the level
                  if (nonempty_ff[lvl]) begin
                     link_we = 1'b1;
                  end else begin
                     head_we          = 1'b1;
                     nonempty_in[lvl] = 1'b1;
                  end
                  tail_we       = 1'b1;
                  ready_in[tid] = 1'b1;
                  result.status = ST_DONE;
               end
            end
            KIND_REMOVE: begin
               if (ready_ff[tid]) begin
                  // Pop from the head; the last one empties the level
                  if (!nonempty_ff[lvl] || tail_rd == tid) begin
                     nonempty_in[lvl] = 1'b0;
                  end else begin
                     head_we = 1'b1;
                     head_wd = link_rd;
                  end
                  ready_in[tid] = 1'b0;
                  result.status = ST_DONE;
               end
            end
            KIND_SETPRI: begin
               result.old_priority = pri_rd;
               if (!ready_ff[tid]) begin
                  pri_in[tid]   = sat_pri;
                  result.status = ST_DONE;
               end
            end
            default: begin
               result.status = ST_NOCHANGE;
            end
         endcase
      end
   end

   // Control state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         ready_ff    <= '0;
         for (int i = 0; i < THREADS; i++) begin
            pri_ff[i] <= '0;
         end
      end else if (fire) begin
         nonempty_ff <= nonempty_in;
         ready_ff    <= ready_in;
         pri_ff      <= pri_in;
      end
   end

   // Link tables, written only by an item that is processed
   always_ff @(posedge clock) begin
      if (fire && head_we) begin
         head_ff[lvl] <= head_wd;
      end
      if (fire && tail_we) begin
         tail_ff[lvl] <= tid;
      end
      if (fire && link_we) begin
         link_ff[link_wa] <= tid;
      end
   end

   `PRQ_ASSERT_HOLDS(a_empty_only_when_idle, clock, reset,
      fire && result.status == ST_EMPTY, nonempty_ff == '0)
   `PRQ_ASSERT_NEXT(a_enqueue_sets_ready, clock, reset,
      fire && kind == KIND_ENQUEUE && result.status == ST_DONE, ready_ff[$past(tid)])
   `PRQ_ASSERT_NEXT(a_refused_keeps_priority, clock, reset,
      fire && kind == KIND_SETPRI && t_ok && result.status == ST_NOCHANGE,
      pri_ff[$past(tid)] == $past(pri_rd))

endmodule

`default_nettype wire

// File: sv/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Priority ready-queue scheduler: one FIFO ready queue per priority level, kept as
// linked lists over the thread table. The tuser kind selects enqueue, remove, set
// priority or schedule; every item gives exactly one result. The block takes one
// item per clock while the result channel is not stalled. An accepted item passes
// through an input register, the queue update in the core, and a result register,
// whose output drives the result channel. The rate is set by the core, which reads
// and rewrites the head, tail, link and flag tables in the same cycle so that each
// item sees the state left by the one before it. A stalled result channel holds
// one item in each register and then drops req_tready. The link tables need no
// clearing after reset; the block is ready as soon as reset is released.
module priority_ready_queue_scheduler
   import prq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] thread, [6:3] new_priority
   input  wire logic [KIND_W-1:0]     req_tuser,   // [1:0] kind

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [2:0] chosen_thread, [6:3] old_priority
   output logic [STATUS_W-1:0]        rsp_tuser    // [1:0] status
);

   logic                in_valid_ff, in_valid_in;
   kind_type            in_kind_ff;
   logic [THREAD_W-1:0] in_thread_ff;
   logic [PRI_W-1:0]    in_pri_ff;

   logic                out_valid_ff, out_valid_in;
   result_type          out_result_ff;

   logic                out_free;
   logic                fire;
   logic                req_accept;
   result_type          core_result;

   // Advance when the result register is empty or being drained
   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff   <= kind_type'(req_tuser);
         in_thread_ff <= req_tdata[THREAD_W-1:0];
         in_pri_ff    <= req_tdata[THREAD_W +: PRI_W];
      end
   end

   prq_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .kind         (in_kind_ff),
      .thread       (in_thread_ff),
      .new_priority (in_pri_ff),
      .result       (core_result)
   );

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_result_ff <= core_result;
      end
   end

   // Drive the result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.status;
   assign rsp_tdata  = RSP_DATA_W'({out_result_ff.old_priority, out_result_ff.chosen_thread});

endmodule

`default_nettype wire
